// ===== hw/rtl/mlfq_pkg.sv =====
package mlfq_pkg;

    localparam int JOB_SLOTS_DEF = 16;

    localparam int ID_W    = 16;
    localparam int LEN_W   = 16;
    localparam int QUANT_W = 12;
    localparam int ALLOT_W = 20;
    localparam int PERIOD_W = 16;
    localparam int CPU_W   = 21;
    localparam int TIME_W  = 32;
    localparam int BOOST_W = 17;

    localparam int S_DATA_W = 32;
    localparam int M_DATA_W = 104;
    localparam int ADDR_W   = 5;
    localparam int APB_W    = 32;

    localparam logic [CPU_W-1:0]   CPU_MAX   = {CPU_W{1'b1}};
    localparam logic [BOOST_W-1:0] BOOST_MAX = {BOOST_W{1'b1}};

    localparam logic [QUANT_W-1:0]  QUANTUM_TOP_RST   = 12'd5;
    localparam logic [ALLOT_W-1:0]  ALLOTMENT_TOP_RST = 20'd10;
    localparam logic [QUANT_W-1:0]  QUANTUM_LOW_RST   = 12'd10;
    localparam logic [ALLOT_W-1:0]  ALLOTMENT_LOW_RST = 20'd1000000;
    localparam logic [PERIOD_W-1:0] BOOST_PERIOD_RST  = 16'd40;

    typedef enum logic [2:0] {
        REG_QUANTUM_TOP   = 3'd0,
        REG_ALLOTMENT_TOP = 3'd1,
        REG_QUANTUM_LOW   = 3'd2,
        REG_ALLOTMENT_LOW = 3'd3,
        REG_BOOST_PERIOD  = 3'd4
    } reg_idx_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_ADD,
        ST_ADD_WR,
        ST_RUN,
        ST_BOOST_RD,
        ST_BOOST_WR,
        ST_SEL,
        ST_SLOT_RD,
        ST_CALC,
        ST_WB
    } state_t;

    typedef struct packed {
        logic take_item;
        logic free_rd;
        logic add_do;
        logic boost_mark;
        logic boost_pop;
        logic boost_push;
        logic boost_end;
        logic run_pop;
        logic slot_rd;
        logic calc;
        logic run_wb;
        logic idle_res;
    } cmd_t;

    typedef struct packed {
        logic in_kind;
        logic boost_due;
        logic low_empty;
        logic both_empty;
        logic out_free;
    } sts_t;

    typedef struct packed {
        logic [QUANT_W-1:0]  quantum_top;
        logic [ALLOT_W-1:0]  allotment_top;
        logic [QUANT_W-1:0]  quantum_low;
        logic [ALLOT_W-1:0]  allotment_low;
        logic [PERIOD_W-1:0] boost_period;
    } cfg_t;

endpackage

// ===== hw/rtl/mlfq_ram.sv =====
module mlfq_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             aclk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== hw/rtl/mlfq_ctrl.sv =====
module mlfq_ctrl (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  mlfq_pkg::sts_t sts,
    output mlfq_pkg::cmd_t cmd
);
    import mlfq_pkg::*;

    state_t state_reg;
    state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        s_tready   = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.take_item = 1'b1;
                    state_next    = sts.in_kind ? ST_RUN : ST_ADD;
                end
            end
            ST_ADD: begin
                cmd.free_rd = 1'b1;
                state_next  = ST_ADD_WR;
            end
            ST_ADD_WR: begin
                if (sts.out_free) begin
                    cmd.add_do = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            ST_RUN: begin
                if (sts.boost_due) begin
                    cmd.boost_mark = 1'b1;
                    state_next     = ST_BOOST_RD;
                end else begin
                    state_next = ST_SEL;
                end
            end
            ST_BOOST_RD: begin
                if (sts.low_empty) begin
                    cmd.boost_end = 1'b1;
                    state_next    = ST_SEL;
                end else begin
                    cmd.boost_pop = 1'b1;
                    state_next    = ST_BOOST_WR;
                end
            end
            ST_BOOST_WR: begin
                cmd.boost_push = 1'b1;
                state_next     = ST_BOOST_RD;
            end
            ST_SEL: begin
                if (sts.both_empty) begin
                    if (sts.out_free) begin
                        cmd.idle_res = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end else begin
                    cmd.run_pop = 1'b1;
                    state_next  = ST_SLOT_RD;
                end
            end
            ST_SLOT_RD: begin
                cmd.slot_rd = 1'b1;
                state_next  = ST_CALC;
            end
            ST_CALC: begin
                cmd.calc   = 1'b1;
                state_next = ST_WB;
            end
            ST_WB: begin
                if (sts.out_free) begin
                    cmd.run_wb = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

endmodule

// ===== hw/rtl/mlfq_dp.sv =====
module mlfq_dp #(
    parameter int JOB_SLOTS = mlfq_pkg::JOB_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  mlfq_pkg::cfg_t                cfg,
    input  logic [mlfq_pkg::S_DATA_W-1:0] s_tdata,
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [mlfq_pkg::M_DATA_W-1:0] m_tdata,
    input  mlfq_pkg::cmd_t                cmd,
    output mlfq_pkg::sts_t                sts
);
    import mlfq_pkg::*;

    localparam int IW = $clog2(JOB_SLOTS);
    localparam int CW = $clog2(JOB_SLOTS + 1);

    function automatic logic [IW-1:0] ring_tail(input logic [IW-1:0] h,
                                                input logic [CW-1:0] c);
        logic [CW:0] s;
        s = {{(CW + 1 - IW){1'b0}}, h} + {1'b0, c};
        if (s >= (CW + 1)'(JOB_SLOTS)) begin
            s = s - (CW + 1)'(JOB_SLOTS);
        end
        return s[IW-1:0];
    endfunction

    function automatic logic [IW-1:0] ring_inc(input logic [IW-1:0] h);
        return (h == IW'(JOB_SLOTS - 1)) ? '0 : h + 1'b1;
    endfunction

    logic [IW-1:0] top_head_reg, top_head_next;
    logic [CW-1:0] top_count_reg, top_count_next;
    logic [IW-1:0] low_head_reg, low_head_next;
    logic [CW-1:0] low_count_reg, low_count_next;
    logic [IW-1:0] free_head_reg, free_head_next;
    logic [CW-1:0] free_count_reg, free_count_next;
    logic [CW-1:0] fresh_reg, fresh_next;
    logic [TIME_W-1:0]  gtime_reg, gtime_next;
    logic [BOOST_W-1:0] boost_reg, boost_next;
    logic boosted_reg, boosted_next;
    logic m_valid_reg, m_valid_next;

    logic [ID_W-1:0]    id_reg;
    logic [LEN_W-1:0]   len_reg;
    logic               level_reg;
    logic [IW-1:0]      slot_reg;
    logic [ID_W-1:0]    pid_reg;
    logic [QUANT_W-1:0] slice_reg;
    logic [LEN_W-1:0]   rem_reg;
    logic [CPU_W-1:0]   cpu_reg;
    logic [M_DATA_W-1:0] m_data_reg;

    logic [IW-1:0]    top_rd, low_rd, free_rd;
    logic [ID_W-1:0]  pid_rd;
    logic [LEN_W-1:0] rem_rd;
    logic [CPU_W-1:0] cpu_rd;

    logic            full, add_commit;
    logic [IW-1:0]   alloc_slot, slot_sel;
    logic            done, clr_cpu, push_low, push_top;
    logic            top_we, low_we, free_we, rem_we, cpu_we;
    logic [IW-1:0]   top_waddr, rem_waddr, cpu_waddr, top_wdata;
    logic [LEN_W-1:0] rem_wdata;
    logic [CPU_W-1:0] cpu_wdata;
    logic [QUANT_W-1:0] quant, slice_c;
    logic [ALLOT_W-1:0] allot;
    logic [CPU_W:0]     cpu_sum;
    logic [BOOST_W:0]   boost_sum;

    assign full       = (free_count_reg == '0) && (fresh_reg == CW'(JOB_SLOTS));
    assign add_commit = cmd.add_do && !full;
    assign alloc_slot = (free_count_reg != '0) ? free_rd : fresh_reg[IW-1:0];
    assign slot_sel   = level_reg ? low_rd : top_rd;

    assign quant   = level_reg ? cfg.quantum_low : cfg.quantum_top;
    assign allot   = level_reg ? cfg.allotment_low : cfg.allotment_top;
    assign slice_c = (rem_rd < {{(LEN_W - QUANT_W){1'b0}}, quant}) ?
                     rem_rd[QUANT_W-1:0] : quant;
    assign cpu_sum = {1'b0, cpu_rd} + {{(CPU_W + 1 - QUANT_W){1'b0}}, slice_c};
    assign boost_sum = {1'b0, boost_reg} + {{(BOOST_W + 1 - QUANT_W){1'b0}}, slice_reg};

    assign done     = (rem_reg == '0);
    assign clr_cpu  = cpu_reg >= {{(CPU_W - ALLOT_W){1'b0}}, allot};
    assign push_low = !done && (clr_cpu || level_reg);
    assign push_top = !done && !push_low;

    assign top_we    = add_commit || cmd.boost_push || (cmd.run_wb && push_top);
    assign top_waddr = ring_tail(top_head_reg, top_count_reg);
    assign top_wdata = add_commit ? alloc_slot : (cmd.boost_push ? low_rd : slot_reg);
    assign low_we    = cmd.run_wb && push_low;
    assign free_we   = cmd.run_wb && done;

    assign rem_we    = add_commit || cmd.run_wb;
    assign rem_waddr = add_commit ? alloc_slot : slot_reg;
    assign rem_wdata = add_commit ? len_reg : rem_reg;
    assign cpu_we    = add_commit || cmd.boost_push || cmd.run_wb;
    assign cpu_waddr = add_commit ? alloc_slot : (cmd.boost_push ? low_rd : slot_reg);
    assign cpu_wdata = (cmd.run_wb && !clr_cpu) ? cpu_reg : '0;

    mlfq_ram #(.WIDTH(IW), .DEPTH(JOB_SLOTS)) u_top_ring (
        .aclk(aclk), .we(top_we), .waddr(top_waddr), .wdata(top_wdata),
        .raddr(top_head_reg), .rdata(top_rd)
    );

    mlfq_ram #(.WIDTH(IW), .DEPTH(JOB_SLOTS)) u_low_ring (
        .aclk(aclk), .we(low_we), .waddr(ring_tail(low_head_reg, low_count_reg)),
        .wdata(slot_reg), .raddr(low_head_reg), .rdata(low_rd)
    );

    mlfq_ram #(.WIDTH(IW), .DEPTH(JOB_SLOTS)) u_free_ring (
        .aclk(aclk), .we(free_we), .waddr(ring_tail(free_head_reg, free_count_reg)),
        .wdata(slot_reg), .raddr(free_head_reg), .rdata(free_rd)
    );

    mlfq_ram #(.WIDTH(ID_W), .DEPTH(JOB_SLOTS)) u_pid_ram (
        .aclk(aclk), .we(add_commit), .waddr(alloc_slot), .wdata(id_reg),
        .raddr(slot_sel), .rdata(pid_rd)
    );

    mlfq_ram #(.WIDTH(LEN_W), .DEPTH(JOB_SLOTS)) u_rem_ram (
        .aclk(aclk), .we(rem_we), .waddr(rem_waddr), .wdata(rem_wdata),
        .raddr(slot_sel), .rdata(rem_rd)
    );

    mlfq_ram #(.WIDTH(CPU_W), .DEPTH(JOB_SLOTS)) u_cpu_ram (
        .aclk(aclk), .we(cpu_we), .waddr(cpu_waddr), .wdata(cpu_wdata),
        .raddr(slot_sel), .rdata(cpu_rd)
    );

    always_comb begin
        top_head_next   = top_head_reg;
        top_count_next  = top_count_reg;
        low_head_next   = low_head_reg;
        low_count_next  = low_count_reg;
        free_head_next  = free_head_reg;
        free_count_next = free_count_reg;
        fresh_next      = fresh_reg;
        gtime_next      = gtime_reg;
        boost_next      = boost_reg;
        boosted_next    = boosted_reg;
        m_valid_next    = m_valid_reg && !m_tready;

        if (cmd.take_item) begin
            boosted_next = 1'b0;
        end
        if (add_commit) begin
            top_count_next = top_count_reg + 1'b1;
            if (free_count_reg != '0) begin
                free_head_next  = ring_inc(free_head_reg);
                free_count_next = free_count_reg - 1'b1;
            end else begin
                fresh_next = fresh_reg + 1'b1;
            end
        end
        if (cmd.boost_mark) begin
            boosted_next = 1'b1;
        end
        if (cmd.boost_pop) begin
            low_head_next  = ring_inc(low_head_reg);
            low_count_next = low_count_reg - 1'b1;
        end
        if (cmd.boost_push) begin
            top_count_next = top_count_reg + 1'b1;
        end
        if (cmd.boost_end) begin
            boost_next = '0;
        end
        if (cmd.run_pop) begin
            if (top_count_reg == '0) begin
                low_head_next  = ring_inc(low_head_reg);
                low_count_next = low_count_reg - 1'b1;
            end else begin
                top_head_next  = ring_inc(top_head_reg);
                top_count_next = top_count_reg - 1'b1;
            end
        end
        if (cmd.run_wb) begin
            gtime_next = gtime_reg + {{(TIME_W - QUANT_W){1'b0}}, slice_reg};
            boost_next = boost_sum[BOOST_W] ? BOOST_MAX : boost_sum[BOOST_W-1:0];
            if (done) begin
                free_count_next = free_count_reg + 1'b1;
            end else if (push_low) begin
                low_count_next = low_count_reg + 1'b1;
            end else begin
                top_count_next = top_count_reg + 1'b1;
            end
        end
        if (cmd.add_do || cmd.run_wb || cmd.idle_res) begin
            m_valid_next = 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            top_head_reg   <= '0;
            top_count_reg  <= '0;
            low_head_reg   <= '0;
            low_count_reg  <= '0;
            free_head_reg  <= '0;
            free_count_reg <= '0;
            fresh_reg      <= '0;
            gtime_reg      <= '0;
            boost_reg      <= '0;
            boosted_reg    <= 1'b0;
            m_valid_reg    <= 1'b0;
        end else begin
            top_head_reg   <= top_head_next;
            top_count_reg  <= top_count_next;
            low_head_reg   <= low_head_next;
            low_count_reg  <= low_count_next;
            free_head_reg  <= free_head_next;
            free_count_reg <= free_count_next;
            fresh_reg      <= fresh_next;
            gtime_reg      <= gtime_next;
            boost_reg      <= boost_next;
            boosted_reg    <= boosted_next;
            m_valid_reg    <= m_valid_next;
        end
    end

    // result beat layout: pid, level, slice_time, remaining, cpu_used,
    // elapsed, done_res, demoted, boosted, idle, rejected, pad
    always_ff @(posedge aclk) begin
        if (cmd.take_item) begin
            id_reg  <= s_tdata[ID_W-1:0];
            len_reg <= s_tdata[S_DATA_W-1:ID_W];
        end
        if (cmd.run_pop) begin
            level_reg <= (top_count_reg == '0);
        end
        if (cmd.slot_rd) begin
            slot_reg <= slot_sel;
        end
        if (cmd.calc) begin
            pid_reg   <= pid_rd;
            slice_reg <= slice_c;
            rem_reg   <= rem_rd - {{(LEN_W - QUANT_W){1'b0}}, slice_c};
            cpu_reg   <= cpu_sum[CPU_W] ? CPU_MAX : cpu_sum[CPU_W-1:0];
        end
        if (cmd.add_do) begin
            m_data_reg <= {1'b0, full, 1'b0, 1'b0, 1'b0, 1'b0, gtime_reg,
                           {CPU_W{1'b0}}, len_reg, {QUANT_W{1'b0}}, 1'b0, id_reg};
        end else if (cmd.idle_res) begin
            m_data_reg <= {1'b0, 1'b0, 1'b1, boosted_reg, 1'b0, 1'b0, gtime_reg,
                           {CPU_W{1'b0}}, {LEN_W{1'b0}}, {QUANT_W{1'b0}}, 1'b0,
                           {ID_W{1'b0}}};
        end else if (cmd.run_wb) begin
            m_data_reg <= {1'b0, 1'b0, 1'b0, boosted_reg,
                           !done && clr_cpu && !level_reg, done, gtime_next,
                           cpu_reg, rem_reg, slice_reg, level_reg, pid_reg};
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

    assign sts.in_kind    = s_tuser;
    assign sts.boost_due  = boost_reg >= {1'b0, cfg.boost_period};
    assign sts.low_empty  = (low_count_reg == '0);
    assign sts.both_empty = (low_count_reg == '0) && (top_count_reg == '0);
    assign sts.out_free   = !m_valid_reg || m_tready;

endmodule

// ===== hw/rtl/mlfq_two_level_scheduler_top.sv =====
// Two-level feedback-queue job scheduler.
// Input channel s_*: one beat is either an add (tuser = 0: tdata carries
// job_id and job_length) or a run (tuser = 1: serve one time slice).
// Result channel m_*: exactly one beat per input beat, in order, giving the
// job served or added, its level, slice time, remaining work, cpu use, the
// global time and the status flags.
// Configuration is an APB slave: quantum_top, allotment_top, quantum_low,
// allotment_low, boost_period at byte addresses 0x00 to 0x10; write while idle.
// Steps, from the accepting state: an add reads the free ring (ST_ADD), then
// writes the job and loads the result (ST_ADD_WR); a run that serves a job
// passes ST_RUN, ST_SEL, ST_SLOT_RD, ST_CALC and ST_WB, and an idle run ends
// at ST_SEL; a boost adds one ST_BOOST_RD plus an ST_BOOST_RD, ST_BOOST_WR
// pair per job it moves out of the low queue. s_tready returns in the cycle
// after the result is loaded. Every slot and ring read has a registered read.
// The next beat is accepted while a result waits in the output register;
// a stalled receiver holds the block at its final step until the result
// register empties.
// Reset (aresetn low, synchronous) empties all queues, frees every job slot,
// clears time and boost counters and loads the default register values.
module mlfq_two_level_scheduler_top #(
    parameter int JOB_SLOTS = mlfq_pkg::JOB_SLOTS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    input  logic [mlfq_pkg::S_DATA_W-1:0] s_tdata,  // job_id, job_length
    input  logic                          s_tuser,  // kind
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // pid, level, slice_time, remaining, cpu_used, elapsed, done_res,
    // demoted, boosted, idle, rejected
    output logic [mlfq_pkg::M_DATA_W-1:0] m_tdata,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [mlfq_pkg::ADDR_W-1:0]   paddr,
    input  logic [mlfq_pkg::APB_W-1:0]    pwdata,
    output logic [mlfq_pkg::APB_W-1:0]    prdata,
    output logic                          pready
);
    import mlfq_pkg::*;

    cfg_t cfg_reg;
    cmd_t cmd;
    sts_t sts;
    logic [2:0] reg_idx;

    assign pready  = 1'b1;
    assign reg_idx = paddr[ADDR_W-1:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.quantum_top   <= QUANTUM_TOP_RST;
            cfg_reg.allotment_top <= ALLOTMENT_TOP_RST;
            cfg_reg.quantum_low   <= QUANTUM_LOW_RST;
            cfg_reg.allotment_low <= ALLOTMENT_LOW_RST;
            cfg_reg.boost_period  <= BOOST_PERIOD_RST;
        end else if (psel && penable && pwrite) begin
            case (reg_idx)
                REG_QUANTUM_TOP:   cfg_reg.quantum_top   <= pwdata[QUANT_W-1:0];
                REG_ALLOTMENT_TOP: cfg_reg.allotment_top <= pwdata[ALLOT_W-1:0];
                REG_QUANTUM_LOW:   cfg_reg.quantum_low   <= pwdata[QUANT_W-1:0];
                REG_ALLOTMENT_LOW: cfg_reg.allotment_low <= pwdata[ALLOT_W-1:0];
                REG_BOOST_PERIOD:  cfg_reg.boost_period  <= pwdata[PERIOD_W-1:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_QUANTUM_TOP:   prdata = {{(APB_W - QUANT_W){1'b0}}, cfg_reg.quantum_top};
            REG_ALLOTMENT_TOP: prdata = {{(APB_W - ALLOT_W){1'b0}}, cfg_reg.allotment_top};
            REG_QUANTUM_LOW:   prdata = {{(APB_W - QUANT_W){1'b0}}, cfg_reg.quantum_low};
            REG_ALLOTMENT_LOW: prdata = {{(APB_W - ALLOT_W){1'b0}}, cfg_reg.allotment_low};
            REG_BOOST_PERIOD:  prdata = {{(APB_W - PERIOD_W){1'b0}}, cfg_reg.boost_period};
            default:           prdata = '0;
        endcase
    end

    mlfq_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .sts     (sts),
        .cmd     (cmd)
    );

    mlfq_dp #(.JOB_SLOTS(JOB_SLOTS)) u_dp (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cfg     (cfg_reg),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .cmd     (cmd),
        .sts     (sts)
    );

endmodule
